>>> hdl/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

  // Characters per weight or tare field
  localparam int FIELD_CHARS = 6;
  localparam int TEXT_W = FIELD_CHARS * 8;
  localparam int CNT_W = 3;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef struct packed {
    logic [TEXT_W-1:0] weight_text;
    logic [TEXT_W-1:0] tare_text;
    logic [1:0]        decimal_places;
    logic              unit_is_kg;
  } result_t;

  function automatic logic is_field_char(input logic [7:0] b);
    is_field_char = ((b >= DIGIT_LO) && (b <= DIGIT_HI)) || (b == SPACE_BYTE);
  endfunction

endpackage

>>> hdl/sfp_if.sv
`timescale 1ns / 1ps

interface sfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if;
  logic                        valid;
  logic                        ready;
  logic [sfp_pkg::TEXT_W-1:0]  weight_text;
  logic [sfp_pkg::TEXT_W-1:0]  tare_text;
  logic [1:0]                  decimal_places;
  logic                        unit_is_kg;

  modport source (output valid, output weight_text, output tare_text,
                  output decimal_places, output unit_is_kg, input ready);
  modport sink (input valid, input weight_text, input tare_text,
                input decimal_places, input unit_is_kg, output ready);
endinterface

>>> hdl/sfp_parse.sv
`timescale 1ns / 1ps

module sfp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  output logic             hit,
  output sfp_pkg::result_t result
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_STAT_A = 3'd1;
  localparam logic [2:0] PH_STAT_B = 3'd2;
  localparam logic [2:0] PH_STAT_C = 3'd3;
  localparam logic [2:0] PH_WEIGHT = 3'd4;
  localparam logic [2:0] PH_TARE   = 3'd5;
  localparam logic [2:0] PH_CR     = 3'd6;
  localparam logic [2:0] PH_CKSUM  = 3'd7;

  logic [2:0]                     phase, phase_next;
  logic [6:0]                     sum, sum_next;
  logic [2:0]                     stat_a, stat_a_next;
  logic [4:0]                     stat_b, stat_b_next;
  logic [sfp_pkg::CNT_W-1:0]      count, count_next;
  logic [sfp_pkg::TEXT_W-1:0]     weight, weight_next;
  logic [sfp_pkg::TEXT_W-1:0]     tare, tare_next;
  logic [6:0]                     sum_add;
  logic [sfp_pkg::CNT_W:0]        count_inc;
  logic                           field_last;
  logic                           char_ok;

  assign sum_add = sum + rx_byte[6:0];
  assign count_inc = {1'b0, count} + (sfp_pkg::CNT_W+1)'(1);
  assign field_last = count_inc >= (sfp_pkg::CNT_W+1)'(sfp_pkg::FIELD_CHARS);
  assign char_ok = sfp_pkg::is_field_char(rx_byte);

  always_comb begin
    phase_next = phase;
    sum_next = sum;
    stat_a_next = stat_a;
    stat_b_next = stat_b;
    count_next = count;
    weight_next = weight;
    tare_next = tare;
    hit = 1'b0;
    case (phase)
      PH_HUNT: begin
        sum_next = rx_byte[6:0];
        if (rx_byte == sfp_pkg::START_BYTE) phase_next = PH_STAT_A;
      end
      PH_STAT_A: begin
        sum_next = sum_add;
        stat_a_next = rx_byte[2:0];
        phase_next = PH_STAT_B;
      end
      PH_STAT_B: begin
        sum_next = sum_add;
        stat_b_next = rx_byte[4:0];
        phase_next = PH_STAT_C;
      end
      PH_STAT_C: begin
        sum_next = sum_add;
        weight_next = '0;
        tare_next = '0;
        count_next = '0;
        phase_next = PH_WEIGHT;
      end
      PH_WEIGHT: begin
        sum_next = sum_add;
        if (!char_ok) begin
          count_next = '0;
          phase_next = PH_HUNT;
        end else begin
          weight_next = {weight[sfp_pkg::TEXT_W-9:0], rx_byte};
          if (field_last) begin
            count_next = '0;
            phase_next = PH_TARE;
          end else begin
            count_next = count_inc[sfp_pkg::CNT_W-1:0];
          end
        end
      end
      PH_TARE: begin
        sum_next = sum_add;
        if (!char_ok) begin
          count_next = '0;
          phase_next = PH_HUNT;
        end else begin
          tare_next = {tare[sfp_pkg::TEXT_W-9:0], rx_byte};
          if (field_last) begin
            count_next = '0;
            phase_next = PH_CR;
          end else begin
            count_next = count_inc[sfp_pkg::CNT_W-1:0];
          end
        end
      end
      PH_CR: begin
        sum_next = sum_add;
        phase_next = (rx_byte == sfp_pkg::CR_BYTE) ? PH_CKSUM : PH_HUNT;
      end
      PH_CKSUM: begin
        // checksum byte ends the frame either way
        hit = (sum_add == 7'd0) && (stat_b[3:1] == 3'd0);
        phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    result.weight_text = weight;
    result.tare_text = tare;
    result.unit_is_kg = stat_b[4];
    case (stat_a)
      3'd3:    result.decimal_places = 2'd1;
      3'd4:    result.decimal_places = 2'd2;
      3'd5:    result.decimal_places = 2'd3;
      default: result.decimal_places = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      sum <= '0;
      stat_a <= '0;
      stat_b <= '0;
      count <= '0;
    end else if (advance) begin
      phase <= phase_next;
      sum <= sum_next;
      stat_a <= stat_a_next;
      stat_b <= stat_b_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      weight <= weight_next;
      tare <= tare_next;
    end
  end

endmodule

>>> hdl/scale_frame_parser.sv
`timescale 1ns / 1ps
// Result valid follows the checksum byte through the input and output registers.
// Throughput: one word per cycle; the input stalls only while a finished
// result sits in the output register and the sink holds ready low.
// Reset (rst, synchronous, active high) returns the parser to the hunt for
// the start byte and empties the input and output registers.

module scale_frame_parser (
  input  logic                 clk,
  input  logic                 rst,
  sfp_byte_if.sink             rx,
  sfp_result_if.source         result
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             advance;
  logic             hit;
  sfp_pkg::result_t parsed;
  sfp_pkg::result_t out_data;

  // Move the held word into the parser when the output register can take a result
  assign advance = in_valid && (!out_valid || result.ready);
  assign rx.ready = !in_valid || !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) in_byte <= rx.rx_byte;
  end

  sfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .hit     (hit),
    .result  (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) out_data <= parsed;
  end

  assign result.valid = out_valid;
  assign result.weight_text = out_data.weight_text;
  assign result.tare_text = out_data.tare_text;
  assign result.decimal_places = out_data.decimal_places;
  assign result.unit_is_kg = out_data.unit_is_kg;

endmodule

>>> hdl/sfp_checker.sv
`timescale 1ns / 1ps

module sfp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rx_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [sfp_pkg::TEXT_W-1:0]  weight_text,
  input logic [sfp_pkg::TEXT_W-1:0]  tare_text,
  input logic [1:0]                  decimal_places,
  input logic                        unit_is_kg
);

  function automatic logic text_ok(input logic [sfp_pkg::TEXT_W-1:0] t);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < sfp_pkg::FIELD_CHARS; i++) begin
      ok = ok && sfp_pkg::is_field_char(t[i*8 +: 8]);
    end
    text_ok = ok;
  endfunction

  // Hold the result word while the sink stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(weight_text) &&
      $stable(tare_text) && $stable(decimal_places) && $stable(unit_is_kg))
    else $error("result word changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid && !res_ready)
    else $error("input stalled without output backpressure");

  a_text_chars: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> text_ok(weight_text) && text_ok(tare_text))
    else $error("result holds a byte that is neither digit nor space");

endmodule

bind scale_frame_parser sfp_checker u_sfp_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_ready       (rx.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .weight_text    (result.weight_text),
  .tare_text      (result.tare_text),
  .decimal_places (result.decimal_places),
  .unit_is_kg     (result.unit_is_kg)
);
